FILE: rtl/fpau_pkg.sv
// ----------------------------------------------------------------------------
// fpau_pkg
// Opcodes, item classes and shared types of the fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package fpau_pkg;

  typedef enum logic [4:0] {
    OP_FROM_INT   = 5'd0,
    OP_FROM_FLOAT = 5'd1,
    OP_TO_INT     = 5'd2,
    OP_TO_FLOAT   = 5'd3,
    OP_ADD        = 5'd4,
    OP_SUB        = 5'd5,
    OP_MUL        = 5'd6,
    OP_DIV        = 5'd7,
    OP_GT         = 5'd8,
    OP_GE         = 5'd9,
    OP_LT         = 5'd10,
    OP_LE         = 5'd11,
    OP_EQ         = 5'd12,
    OP_NE         = 5'd13,
    OP_MIN        = 5'd14,
    OP_MAX        = 5'd15,
    OP_INC        = 5'd16,
    OP_DEC        = 5'd17
  } opcode_e;

  // Which part of the back end finishes an item
  typedef enum logic [2:0] {
    CL_SIMPLE,
    CL_MUL,
    CL_DIV,
    CL_FROMF,
    CL_TOF,
    CL_NONE
  } op_class_e;

  // How stage two completes the result
  typedef enum logic [3:0] {
    FIN_DIRECT = 4'b0001,
    FIN_MUL    = 4'b0010,
    FIN_TOF    = 4'b0100,
    FIN_FROMF  = 4'b1000
  } fin_e;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_e;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [4:0]  cmd;
    op_class_e   cls;
    logic [31:0] a;
    logic [31:0] b;
  } item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              push;
    logic              pop;
  } qstat_t;

endpackage

FILE: rtl/fpau_if.sv
// ----------------------------------------------------------------------------
// fpau_if
// Valid/ready channels of the fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
interface fpau_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cmd;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface fpau_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_word;
  logic        compare_true;
  logic        divide_by_zero;

  modport source (output valid, result_word, compare_true, divide_by_zero, input ready);
  modport sink   (input valid, result_word, compare_true, divide_by_zero, output ready);
endinterface

FILE: rtl/fpau_front.sv
// ----------------------------------------------------------------------------
// fpau_front
// Accepts input transactions, classifies the opcode and pushes to the queue.
// ----------------------------------------------------------------------------
module fpau_front
  import fpau_pkg::*;
(
  fpau_in_if.sink in_i,
  input  logic    q_full_i,
  output logic    q_push_o,
  output item_t   q_item_o
);

  function automatic op_class_e classify(input logic [4:0] cmd);
    op_class_e cls;
    cls = CL_NONE;
    unique case (opcode_e'(cmd))
      OP_FROM_FLOAT: cls = CL_FROMF;
      OP_TO_FLOAT:   cls = CL_TOF;
      OP_MUL:        cls = CL_MUL;
      OP_DIV:        cls = CL_DIV;
      OP_FROM_INT, OP_TO_INT, OP_ADD, OP_SUB, OP_GT, OP_GE, OP_LT, OP_LE,
      OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC: cls = CL_SIMPLE;
      default:       cls = CL_NONE;
    endcase
    return cls;
  endfunction

  assign in_i.ready    = !q_full_i;
  assign q_push_o      = in_i.valid && !q_full_i;
  assign q_item_o.cmd  = in_i.cmd;
  assign q_item_o.cls  = classify(in_i.cmd);
  assign q_item_o.a    = in_i.operand_a;
  assign q_item_o.b    = in_i.operand_b;

endmodule

FILE: rtl/fpau_queue.sv
// ----------------------------------------------------------------------------
// fpau_queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module fpau_queue
  import fpau_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  input  logic   pop_i,
  output item_t  item_o,
  output logic   full_o,
  output logic   empty_o,
  output qstat_t stat_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  assign stat_o.count = cnt_q;
  assign stat_o.push  = push_i;
  assign stat_o.pop   = pop_i;

endmodule

FILE: rtl/fpau_div.sv
// ----------------------------------------------------------------------------
// fpau_div
// Iterative restoring divider for unsigned magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fpau_div
  import fpau_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [31+FRAC_BITS:0] dividend_i,
  input  logic [31:0]           divisor_i,
  input  logic                  ack_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [31+FRAC_BITS:0] quot_o
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW);

  div_state_e    state_q, state_d;
  logic [CW-1:0] cnt_q;
  logic [31:0]   rem_q, dsr_q;
  logic [DW-1:0] quo_q;
  logic [32:0]   rem_sh, rem_sub;
  logic          take;

  assign rem_sh  = {rem_q, quo_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign take    = !rem_sub[32];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: if (start_i) state_d = DIV_RUN;
      DIV_RUN:  if (cnt_q == '0) state_d = DIV_DONE;
      DIV_DONE: if (ack_i) state_d = DIV_IDLE;
      default:  state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= DIV_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
      cnt_q <= CW'(DW - 1);
    end else if (state_q == DIV_RUN) begin
      rem_q <= take ? rem_sub[31:0] : rem_sh[31:0];
      quo_q <= {quo_q[DW-2:0], take};
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign busy_o = state_q != DIV_IDLE;
  assign done_o = state_q == DIV_DONE;
  assign quot_o = quo_q;

endmodule

FILE: rtl/fpau_back.sv
// ----------------------------------------------------------------------------
// fpau_back
// Execution pipeline: operand stage, finishing stage and output register.
// ----------------------------------------------------------------------------
module fpau_back
  import fpau_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  fpau_out_if.source  out_o
);

  localparam int DW = 32 + FRAC_BITS;

  // stage one
  logic        s1_valid_q;
  item_t       s1_q;
  // stage two
  logic              s2_valid_q;
  fin_e              s2_fin_q;
  logic [31:0]       s2_res_q;
  logic              s2_cmp_q, s2_dz_q;
  logic [63:0]       s2_prod_q;
  logic              s2_sgn_q;
  logic [31:0]       s2_mag_q;
  logic [4:0]        s2_lz_q;
  logic [23:0]       s2_sig_q;
  logic signed [9:0] s2_sh_q;
  // output register
  logic        out_valid_q;
  logic [31:0] out_res_q;
  logic        out_cmp_q, out_dz_q;

  logic out_en, s2_free, s1_done, s1_adv, s1_load;

  // divider
  logic          div_start, div_busy, div_done;
  logic [DW-1:0] div_quot, div_dividend;
  logic [31:0]   abs_a, abs_b, q_lo;
  logic          b_zero;

  assign out_en  = !out_valid_q || out_o.ready;
  assign s2_free = !s2_valid_q || out_en;
  assign b_zero  = s1_q.b == '0;
  assign s1_done = s1_q.cls != CL_DIV || b_zero || div_done;
  assign s1_adv  = s1_valid_q && s1_done && s2_free;
  assign s1_load = !q_empty_i && (!s1_valid_q || s1_adv);
  assign q_pop_o = s1_load;

  assign abs_a        = s1_q.a[31] ? (32'd0 - s1_q.a) : s1_q.a;
  assign abs_b        = s1_q.b[31] ? (32'd0 - s1_q.b) : s1_q.b;
  assign div_dividend = DW'(abs_a) << FRAC_BITS;
  assign div_start    = s1_valid_q && s1_q.cls == CL_DIV && !b_zero && !div_busy;

  fpau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (abs_b),
    .ack_i      (s1_adv),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign q_lo = div_quot[31:0];

  function automatic logic [4:0] lead_zeros(input logic [31:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(31 - i);
    end
    return n;
  endfunction

  // ---------------- stage one: operands and simple ops ----------------
  logic signed [31:0] sa, sb;
  fin_e               a_fin;
  logic [31:0]        a_res;
  logic               a_cmp, a_dz;
  logic [7:0]         f_exp;
  logic [22:0]        f_man;
  logic [8:0]         f_eeff;
  logic signed [9:0]  f_sh;

  assign sa     = $signed(s1_q.a);
  assign sb     = $signed(s1_q.b);
  assign f_exp  = s1_q.a[30:23];
  assign f_man  = s1_q.a[22:0];
  assign f_eeff = (f_exp == '0) ? 9'd1 : {1'b0, f_exp};
  assign f_sh   = $signed({1'b0, f_eeff}) - 10'sd150 + 10'(FRAC_BITS);

  always_comb begin
    a_fin = FIN_DIRECT;
    a_res = '0;
    a_cmp = 1'b0;
    a_dz  = 1'b0;
    unique case (opcode_e'(s1_q.cmd))
      OP_FROM_INT: a_res = s1_q.a << FRAC_BITS;
      OP_FROM_FLOAT: begin
        if (f_exp == 8'hFF) begin
          if (f_man != '0) a_res = '0;
          else a_res = s1_q.a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (f_exp == '0 && f_man == '0) begin
          a_res = '0;
        end else begin
          a_fin = FIN_FROMF;
        end
      end
      OP_TO_INT:   a_res = 32'(sa >>> FRAC_BITS);
      OP_TO_FLOAT: if (s1_q.a != '0) a_fin = FIN_TOF;
      OP_ADD:      a_res = s1_q.a + s1_q.b;
      OP_SUB:      a_res = s1_q.a - s1_q.b;
      OP_MUL:      a_fin = FIN_MUL;
      OP_DIV: begin
        if (b_zero) a_dz = 1'b1;
        else a_res = (s1_q.a[31] ^ s1_q.b[31]) ? (32'd0 - q_lo) : q_lo;
      end
      OP_GT:  a_cmp = sa > sb;
      OP_GE:  a_cmp = sa >= sb;
      OP_LT:  a_cmp = sa < sb;
      OP_LE:  a_cmp = sa <= sb;
      OP_EQ:  a_cmp = sa == sb;
      OP_NE:  a_cmp = sa != sb;
      OP_MIN: a_res = (sa > sb) ? s1_q.b : s1_q.a;
      OP_MAX: a_res = (sa < sb) ? s1_q.b : s1_q.a;
      OP_INC: a_res = s1_q.a + 32'd1;
      OP_DEC: a_res = s1_q.a - 32'd1;
      default: a_res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv) s2_valid_q <= 1'b1;
      else if (out_en) s2_valid_q <= 1'b0;
      if (s2_valid_q && out_en) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) s1_q <= q_item_i;
    if (s1_adv) begin
      s2_fin_q  <= a_fin;
      s2_res_q  <= a_res;
      s2_cmp_q  <= a_cmp;
      s2_dz_q   <= a_dz;
      s2_prod_q <= 64'(64'(sa) * 64'(sb));
      s2_sgn_q  <= s1_q.a[31];
      s2_mag_q  <= abs_a;
      s2_lz_q   <= lead_zeros(abs_a);
      s2_sig_q  <= {(f_exp != '0), f_man};
      s2_sh_q   <= f_sh;
    end
  end

  // ---------------- stage two: finish shifts and rounding ----------------
  logic [31:0] b_res;
  logic [31:0] t_norm;
  logic        t_rnd;
  logic [24:0] t_keep;
  logic [8:0]  t_exp;
  logic [22:0] t_man;
  logic [63:0] f_mag;
  logic [9:0]  f_n;
  logic [31:0] f_res;

  always_comb begin
    t_norm = s2_mag_q << s2_lz_q;
    // round to nearest even on the bits below the 24-bit significand
    t_rnd  = t_norm[7] && ((|t_norm[6:0]) || t_norm[8]);
    t_keep = {1'b0, t_norm[31:8]} + 25'(t_rnd);
    t_exp  = 9'd31 - 9'(s2_lz_q) + 9'd127 - 9'(FRAC_BITS) + 9'(t_keep[24]);
    t_man  = t_keep[24] ? t_keep[23:1] : t_keep[22:0];
  end

  always_comb begin
    f_n   = 10'd0 - 10'(s2_sh_q);
    f_mag = '0;
    if (!s2_sh_q[9]) begin
      if (s2_sh_q > 10'sd39) f_mag = 64'hFF_FFFF_FFFF;
      else f_mag = 64'(s2_sig_q) << s2_sh_q[5:0];
    end else if (f_n <= 10'd25) begin
      f_mag = (64'(s2_sig_q) + (64'd1 << (f_n[4:0] - 5'd1))) >> f_n[4:0];
    end
    if (s2_sgn_q) begin
      if (f_mag >= 64'h8000_0000) f_res = 32'h8000_0000;
      else f_res = 32'd0 - f_mag[31:0];
    end else begin
      if (f_mag > 64'h7FFF_FFFF) f_res = 32'h7FFF_FFFF;
      else f_res = f_mag[31:0];
    end
  end

  always_comb begin
    unique case (s2_fin_q)
      FIN_MUL:   b_res = s2_prod_q[FRAC_BITS +: 32];
      FIN_TOF:   b_res = {s2_sgn_q, t_exp[7:0], t_man};
      FIN_FROMF: b_res = f_res;
      default:   b_res = s2_res_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && out_en) begin
      out_res_q <= b_res;
      out_cmp_q <= s2_cmp_q;
      out_dz_q  <= s2_dz_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_word    = out_res_q;
  assign out_o.compare_true   = out_cmp_q;
  assign out_o.divide_by_zero = out_dz_q;

endmodule

FILE: rtl/fixed_point_arith_unit_core.sv
// ----------------------------------------------------------------------------
// fixed_point_arith_unit_core
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one operation per transaction: cmd, operand_a, operand_b.
//   out_o returns one transaction per operation, in order: result_word,
//   compare_true and divide_by_zero.
//   The front classifies the opcode and writes a two-entry queue; the back
//   end runs an operand stage, a finishing stage and an output register.
//   An accepted operation passes the queue, stage one, stage two and the
//   output register on its way to out_o.valid. Throughput is one operation
//   per cycle while out_o.ready is high and no div runs. A div with a nonzero
//   divisor runs the bit-serial divider, one quotient bit per cycle, while the
//   back end holds later operations; the queue keeps taking input until full.
//   When out_o.ready is low the output register holds its result and the
//   pipeline and then the queue fill before in_i.ready drops.
//   Reset empties the queue and all pipeline stages; no result is pending.
// ----------------------------------------------------------------------------
module fixed_point_arith_unit_core
  import fpau_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpau_in_if.sink    in_i,
  fpau_out_if.source out_o
);

  logic   q_push, q_pop, q_full, q_empty;
  item_t  q_wr_item, q_rd_item;
  qstat_t q_stat;

  fpau_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_wr_item)
  );

  fpau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .pop_i   (q_pop),
    .item_o  (q_rd_item),
    .full_o  (q_full),
    .empty_o (q_empty),
    .stat_o  (q_stat)
  );

  fpau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_item_i  (q_rd_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_q_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.pop |-> q_stat.count != '0)
    else $error("pop from empty queue");

  a_q_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.push && !q_stat.pop) |=> q_stat.count == $past(q_stat.count) + 1'b1)
    else $error("queue count lost a push");

  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.divide_by_zero) |-> (out_o.result_word == '0 &&
                                              !out_o.compare_true))
    else $error("divide by zero with nonzero result");
`endif

endmodule

FILE: bench/fixed_point_arith_unit_core_tb.sv
// ----------------------------------------------------------------------------
// fixed_point_arith_unit_core_tb
// Self-checking bench for the fixed-point ALU: directed corner operations,
// then random traffic with random gaps and stalls on both channels, a long
// output hold-off to fill the pipeline, and in-order result checking.
// ----------------------------------------------------------------------------
module fixed_point_arith_unit_core_tb;
  import fpau_pkg::*;

  localparam int FB = 8;
  localparam int N_RANDOM = 1700;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [4:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
  } alu_op_t;

  typedef struct {
    logic [31:0] word;
    logic        cmp;
    logic        dz;
  } alu_res_t;

  logic clk_i;
  logic rst_ni;

  fpau_in_if  in_ch ();
  fpau_out_if out_ch ();

  fixed_point_arith_unit_core #(.FRAC_BITS(FB)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  alu_op_t  pending_ops[$];
  alu_res_t expected_res[$];
  int       mismatches;
  bit       stim_done;
  bit       long_hold_done;
  int       hold_off;
  int       in_gap;
  int       out_gap;
  int       idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // float bits to fixed, round half away from zero, saturate
  function automatic logic [31:0] float_to_q(logic [31:0] f);
    logic [7:0]  ex;
    logic [23:0] sig;
    logic [63:0] mag;
    int          sh;
    ex = f[30:23];
    sig = {(ex != 8'd0), f[22:0]};
    if (ex == 8'hFF) return (f[22:0] != 0) ? 32'h0 : (f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    if (sig == 0) return 32'h0;
    sh = ((ex != 0) ? int'(ex) : 1) - 150 + FB;
    if (sh >= 0) mag = (sh > 39) ? 64'hFF_FFFF_FFFF : (64'(sig) << sh);
    else if (-sh > 25) mag = 64'h0;
    else mag = (64'(sig) + (64'h1 << (-sh - 1))) >> (-sh);
    if (f[31]) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // fixed to float bits, round to nearest even
  function automatic logic [31:0] q_to_float(logic [31:0] v);
    logic [31:0] mag;
    logic [31:0] keep;
    logic [31:0] rem;
    logic [31:0] half;
    int          p;
    int          r;
    mag = v[31] ? -v : v;
    if (mag == 0) return 32'h0;
    p = 31;
    while (!mag[p]) p--;
    if (p > 23) begin
      r = p - 23;
      rem = mag & ((32'h1 << r) - 1);
      half = 32'h1 << (r - 1);
      keep = mag >> r;
      if (rem > half || (rem == half && keep[0])) keep++;
      if (keep == 32'h100_0000) begin
        keep = keep >> 1;
        p++;
      end
    end else begin
      keep = mag << (23 - p);
    end
    return {v[31], 8'(p - FB + 127), keep[22:0]};
  endfunction

  function automatic alu_res_t alu_predict(alu_op_t op);
    alu_res_t    r;
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic signed [63:0] prod;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    sa = op.a;
    sb = op.b;
    r = '{32'h0, 1'b0, 1'b0};
    case (op.cmd)
      OP_FROM_INT:   r.word = op.a << FB;
      OP_FROM_FLOAT: r.word = float_to_q(op.a);
      OP_TO_INT:     r.word = sa >>> FB;
      OP_TO_FLOAT:   r.word = q_to_float(op.a);
      OP_ADD:        r.word = op.a + op.b;
      OP_SUB:        r.word = op.a - op.b;
      OP_MUL: begin
        prod = 64'(sa) * 64'(sb);
        r.word = 32'(prod >>> FB);
      end
      OP_DIV: begin
        if (op.b == 0) begin
          r.dz = 1'b1;
        end else begin
          ma = (sa < 0) ? 64'(-64'(sa)) : 64'(sa);
          mb = (sb < 0) ? 64'(-64'(sb)) : 64'(sb);
          q = (ma << FB) / mb;
          r.word = ((sa < 0) != (sb < 0)) ? 32'(-q) : q[31:0];
        end
      end
      OP_GT:  r.cmp = sa > sb;
      OP_GE:  r.cmp = sa >= sb;
      OP_LT:  r.cmp = sa < sb;
      OP_LE:  r.cmp = sa <= sb;
      OP_EQ:  r.cmp = sa == sb;
      OP_NE:  r.cmp = sa != sb;
      OP_MIN: r.word = (sa > sb) ? op.b : op.a;
      OP_MAX: r.word = (sa < sb) ? op.b : op.a;
      OP_INC: r.word = op.a + 1;
      OP_DEC: r.word = op.a - 1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000 + $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return 32'h8000_0000 + $urandom_range(0, 2);
      3: return 32'h7FFF_FFFF - $urandom_range(0, 2);
      4: return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_float();
    logic [7:0] ex;
    case ($urandom_range(0, 5))
      0: ex = 8'hFF;
      1: ex = 8'h00;
      2: ex = 8'(150 - FB + $urandom_range(0, 40) - 20);
      default: ex = 8'($urandom_range(100, 170));
    endcase
    return {1'($urandom), ex, 23'($urandom)};
  endfunction

  task automatic add_op(logic [4:0] c, logic [31:0] a, logic [31:0] b);
    alu_op_t op;
    op.cmd = c;
    op.a = a;
    op.b = b;
    pending_ops.push_back(op);
  endtask

  initial begin
    logic [4:0] c;
    add_op(OP_FROM_INT, 32'h0080_0001, 32'h0);
    add_op(OP_FROM_FLOAT, 32'h7FC0_0000, 32'h0);   // NaN
    add_op(OP_FROM_FLOAT, 32'hFF80_0000, 32'h0);   // -inf
    add_op(OP_FROM_FLOAT, 32'h7F80_0000, 32'h0);   // +inf
    add_op(OP_FROM_FLOAT, 32'h8000_0000, 32'h0);   // -0.0
    add_op(OP_FROM_FLOAT, 32'h3BC0_0000, 32'h0);   // half ulp ties
    add_op(OP_TO_INT, 32'h8000_0000, 32'h0);
    add_op(OP_TO_FLOAT, 32'h7FFF_FFFF, 32'h0);
    add_op(OP_TO_FLOAT, 32'h8000_0000, 32'h0);
    add_op(OP_ADD, 32'h7FFF_FFFF, 32'h1);
    add_op(OP_SUB, 32'h8000_0000, 32'h1);
    add_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    add_op(OP_MUL, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    add_op(OP_DIV, 32'h1234_5678, 32'h0);          // zero divisor
    add_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    add_op(OP_DIV, 32'hFFFF_FF00, 32'h0000_0300);
    for (int k = OP_GT; k <= OP_MAX; k++) add_op(5'(k), 32'h8000_0000, 32'h7FFF_FFFF);
    add_op(OP_INC, 32'hFFFF_FFFF, 32'h0);
    add_op(OP_DEC, 32'h0, 32'hFFFF_FFFF);
    add_op(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // unused opcode
    for (int i = 0; i < N_RANDOM; i++) begin
      // few divides, since each one with a nonzero divisor stalls the back end
      c = ($urandom_range(0, 19) == 0) ? 5'(OP_DIV) : 5'($urandom_range(0, 17));
      if ($urandom_range(0, 29) == 0) c = 5'($urandom_range(18, 31));
      if ((c == OP_DIV || c == OP_MUL) && $urandom_range(0, 7) == 0)
        add_op(c, rand_operand(), 32'h0);
      else
        add_op(c, (c == OP_FROM_FLOAT) ? rand_float() : rand_operand(), rand_operand());
    end
  end

  // sender
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= '0;
      in_ch.operand_a <= '0;
      in_ch.operand_b <= '0;
      in_gap <= 0;
      stim_done <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_res.push_back(alu_predict('{in_ch.cmd, in_ch.operand_a, in_ch.operand_b}));
        void'(pending_ops.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        // head of queue is the item just accepted until it is popped above
        if (pending_ops.size() == 0) begin
          in_ch.valid <= 1'b0;
          stim_done <= 1'b1;
        end else if (in_gap > 0) begin
          in_ch.valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.cmd <= pending_ops[0].cmd;
          in_ch.operand_a <= pending_ops[0].a;
          in_ch.operand_b <= pending_ops[0].b;
          in_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
        end
      end
    end
  end

  // receiver with one long hold-off early in the random part
  always_ff @(posedge clk_i or negedge rst_ni) begin
    alu_res_t exp_r;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
      hold_off <= 0;
      long_hold_done <= 1'b0;
      mismatches <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_res.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h", out_ch.result_word);
        end else begin
          exp_r = expected_res.pop_front();
          if (out_ch.result_word !== exp_r.word || out_ch.compare_true !== exp_r.cmp ||
              out_ch.divide_by_zero !== exp_r.dz) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp %h/%b/%b got %h/%b/%b", exp_r.word, exp_r.cmp,
                       exp_r.dz, out_ch.result_word, out_ch.compare_true,
                       out_ch.divide_by_zero);
          end
        end
      end
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off <= hold_off - 1;
      end else if (!long_hold_done && pending_ops.size() <= N_RANDOM - 100) begin
        out_ch.ready <= 1'b0;
        hold_off <= 300;
        long_hold_done <= 1'b1;
        out_gap <= -1;
      end else if (out_gap > 0) begin
        out_ch.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_gap == 0)
          out_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
        else if (out_ch.valid)
          out_gap <= 0;
      end
    end
  end

  // watchdog and end of run
  initial begin
    rst_ni = 1'b0;
    idle_cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
      if (stim_done && expected_res.size() == 0) begin
        repeat (60) @(posedge clk_i);
        if (mismatches == 0 && !out_ch.valid) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
rtl/fpau_pkg.sv
rtl/fpau_if.sv
rtl/fpau_front.sv
rtl/fpau_queue.sv
rtl/fpau_div.sv
rtl/fpau_back.sv
rtl/fixed_point_arith_unit_core.sv
bench/fixed_point_arith_unit_core_tb.sv
